// ----- design/sst_pkg.sv -----
// Shared types and constants for the sleep slot timer.
// No dependencies; imported by sst_ctrl, sst_dp and the top level (not by sst_ram).
package sst_pkg;

  localparam int unsigned SlotsDef    = 16;
  localparam logic [31:0] MaxDuration = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_SLEEP  = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    KIND_WOKEN     = 4'd0,
    KIND_TICK_DONE = 4'd1,
    KIND_SLEPT     = 4'd2,
    KIND_ZERO_DUR  = 4'd3,
    KIND_TOO_LONG  = 4'd4,
    KIND_FULL      = 4'd5,
    KIND_CANCELLED = 4'd6,
    KIND_NOT_OWNER = 4'd7,
    KIND_STATUS    = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_CANCEL
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  task_id;
    logic [31:0] duration;
    logic [3:0]  slot_index;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic [7:0]  woken_task;
    logic [31:0] tick_count;
    logic [4:0]  occupied;
    logic        last;
  } rsp_t;

  // One entry of the slot table memory.
  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] wake;
  } slot_ent_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic cancel_fin;
    logic tick_fin;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic scan_last;
  } stat_t;

endpackage

// ----- design/sst_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sst_ctrl.sv -----
// Controller FSM of the sleep slot timer: sequences accept, slot scan,
// cancel lookup and tick completion. Depends on sst_pkg.
module sst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  sst_pkg::mode_e in_mode_i,
  output logic           in_ready_o,
  input  sst_pkg::stat_t stat_i,
  output sst_pkg::cmd_t  cmd_o
);
  import sst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (in_mode_i == MODE_TICK) begin
            state_d = ST_SCAN;
          end else if (in_mode_i == MODE_CANCEL) begin
            state_d = ST_CANCEL;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.out_free) begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.scan_last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.tick_fin = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_CANCEL: begin
        if (stat_i.out_free) begin
          cmd_o.cancel_fin = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_scan_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cmd_o.scan_step && stat_i.scan_last) |=> (state_q == ST_DONE))
    else $error("scan did not close with tick done");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.scan_step, cmd_o.cancel_fin, cmd_o.tick_fin}))
    else $error("more than one command at once");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("request taken outside idle");

endmodule

// ----- design/sst_dp.sv -----
// Datapath of the sleep slot timer: tick counter, valid bits, occupancy,
// slot table memory (sst_ram), scan index and result register. Depends on sst_pkg and sst_ram.
module sst_dp #(
  parameter int unsigned Slots = sst_pkg::SlotsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sst_pkg::req_t in_req_i,
  input  sst_pkg::cmd_t cmd_i,
  output sst_pkg::stat_t stat_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sst_pkg::rsp_t out_rsp_o
);
  import sst_pkg::*;

  localparam int unsigned AW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned OW = $clog2(Slots + 1);
  localparam int unsigned EW = $bits(slot_ent_t);

  logic [31:0]      cnt_q, cnt_d;
  logic [Slots-1:0] valid_q, valid_d;
  logic [OW-1:0]    occ_q, occ_d;
  logic [AW-1:0]    scan_q, scan_d;
  logic [7:0]       task_q, task_d;
  logic [3:0]       idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  logic             out_free;
  logic             out_load;
  logic             ram_we;
  slot_ent_t        ram_wdata;
  logic [EW-1:0]    ram_rdata;
  slot_ent_t        rd_ent;
  logic [31:0]      diff;
  logic             hit;
  logic             in_range;
  logic             free_found;
  logic [AW-1:0]    free_idx;

  assign out_free = !out_valid_q || out_ready_i;
  assign rd_ent   = slot_ent_t'(ram_rdata);
  assign diff     = cnt_q - rd_ent.wake;
  // deadline reached when the wraparound difference is not negative
  assign hit      = valid_q[scan_q] && !diff[31];
  assign in_range = 32'(idx_q) < 32'(Slots);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < Slots; i++) begin
      if (!valid_q[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    occ_d       = occ_q;
    scan_d      = scan_q;
    task_d      = task_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_wdata.task_id = in_req_i.task_id;
    ram_wdata.wake    = cnt_q + in_req_i.duration;

    out_d.slot       = '0;
    out_d.woken_task = '0;
    out_d.tick_count = cnt_q;
    out_d.occupied   = 5'(occ_q);
    out_d.last       = 1'b1;

    if (cmd_i.accept) begin
      task_d = in_req_i.task_id;
      idx_d  = in_req_i.slot_index;
      scan_d = '0;
      unique case (in_req_i.mode)
        MODE_TICK: begin
          cnt_d = cnt_q + 32'd1;
        end
        MODE_SLEEP: begin
          out_load = 1'b1;
          if (in_req_i.duration == '0) begin
            out_d.kind = KIND_ZERO_DUR;
          end else if (in_req_i.duration > MaxDuration) begin
            out_d.kind = KIND_TOO_LONG;
          end else if (!free_found) begin
            out_d.kind = KIND_FULL;
          end else begin
            ram_we            = 1'b1;
            valid_d[free_idx] = 1'b1;
            occ_d             = occ_q + OW'(1);
            out_d.kind        = KIND_SLEPT;
            out_d.slot        = 4'(free_idx);
            out_d.woken_task  = in_req_i.task_id;
            out_d.occupied    = 5'(occ_d);
          end
        end
        MODE_CANCEL: begin
          scan_d = AW'(in_req_i.slot_index);
        end
        MODE_QUERY: begin
          out_load   = 1'b1;
          out_d.kind = KIND_STATUS;
        end
        default: ;
      endcase
    end else if (cmd_i.scan_step) begin
      scan_d = scan_q + AW'(1);
      if (hit) begin
        out_load         = 1'b1;
        valid_d[scan_q]  = 1'b0;
        occ_d            = occ_q - OW'(1);
        out_d.kind       = KIND_WOKEN;
        out_d.slot       = 4'(scan_q);
        out_d.woken_task = rd_ent.task_id;
        out_d.occupied   = 5'(occ_d);
        out_d.last       = 1'b0;
      end
    end else if (cmd_i.cancel_fin) begin
      out_load   = 1'b1;
      out_d.slot = idx_q;
      if (in_range && valid_q[scan_q]) begin
        out_d.woken_task = rd_ent.task_id;
        if (rd_ent.task_id == task_q) begin
          valid_d[scan_q] = 1'b0;
          occ_d           = occ_q - OW'(1);
          out_d.kind      = KIND_CANCELLED;
          out_d.occupied  = 5'(occ_d);
        end else begin
          out_d.kind = KIND_NOT_OWNER;
        end
      end else begin
        out_d.kind = KIND_NOT_OWNER;
      end
    end else if (cmd_i.tick_fin) begin
      out_load   = 1'b1;
      out_d.kind = KIND_TICK_DONE;
    end

    if (!out_load) begin
      out_d = out_q;
    end
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      valid_q     <= '0;
      occ_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
    idx_q  <= idx_d;
    out_q  <= out_d;
  end

  // read address follows the scan index so the read data holds during a stall
  sst_ram #(
    .Width(EW),
    .Depth(Slots)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx),
    .wdata_i(ram_wdata),
    .raddr_i(scan_d),
    .rdata_o(ram_rdata)
  );

  assign stat_o.out_free  = out_free;
  assign stat_o.scan_last = (scan_q == AW'(Slots - 1));
  assign out_valid_o      = out_valid_q;
  assign out_rsp_o        = out_q;

  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) == 32'($countones(valid_q)))
    else $error("occupancy count out of step with valid bits");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over a pending one");

  a_wake_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_step && hit) |=> !valid_q[$past(scan_q)])
    else $error("woken slot still valid");

endmodule

// ----- design/sleep_slot_timer_top.sv -----
// Channel   Dir  Handshake              Payload
// in        in   in_valid_i/in_ready_o  in_req_i  (sst_pkg::req_t)
// out       out  out_valid_o/out_ready_i out_rsp_o (sst_pkg::rsp_t)
//
// Sleep, query: the result is registered when the request is accepted. Cancel: waits on the table memory read.
// Tick: accept, one slot checked per cycle while the output register is free, then the tick done result.
// Reset clears the counter and slot valid bits at once; no clearing pass.
// A result waiting in the output register stalls the scan, not the table state.
// Top level of the sleep slot timer; depends on sst_pkg, sst_ctrl, sst_dp, sst_ram.
module sleep_slot_timer_top #(
  parameter int unsigned Slots = sst_pkg::SlotsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sst_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sst_pkg::rsp_t out_rsp_o
);
  import sst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_mode_i (in_req_i.mode),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sst_dp #(
    .Slots(Slots)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule
